// File: rtl/core/ebalu_pkg.sv
package ebalu_pkg;

  localparam int unsigned DATA_W = 8;
  localparam int unsigned MODE_W = 3;
  localparam int unsigned MAG_W  = 12;
  localparam int unsigned SVAL_W = MAG_W + 1;
  localparam int unsigned SUM_W  = MAG_W + 2;
  localparam int unsigned SMAG_W = MAG_W + 1;

  typedef enum logic [MODE_W-1:0] {
    MODE_IADD = 3'd0,
    MODE_FADD = 3'd1,
    MODE_OR   = 3'd2,
    MODE_AND  = 3'd3,
    MODE_XOR  = 3'd4
  } mode_t;

  typedef logic [DATA_W-1:0] data_t;

endpackage

// File: rtl/core/ebalu_in_if.sv
interface ebalu_in_if import ebalu_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  data_t             operand_a;
  data_t             operand_b;

  modport source (output valid, output mode, output operand_a, output operand_b,
                  input ready);
  modport sink (input valid, input mode, input operand_a, input operand_b,
                output ready);
endinterface

// File: rtl/core/ebalu_out_if.sv
interface ebalu_out_if import ebalu_pkg::*; ();
  logic  valid;
  logic  ready;
  data_t result;

  modport source (output valid, output result, input ready);
  modport sink (input valid, input result, output ready);
endinterface

// File: rtl/core/ebalu_norm.sv
module ebalu_norm import ebalu_pkg::*; (
  input  logic              sign,
  input  logic [SMAG_W-1:0] mag,
  output data_t             code
);

  logic       found;
  logic [2:0] exp_field;
  logic [3:0] frac;

  always_comb begin
    found     = 1'b0;
    exp_field = '0;
    frac      = '0;
    for (int i = 4; i < SMAG_W; i++) begin
      if (mag[i]) begin
        found     = 1'b1;
        exp_field = 3'(i - 4);
        frac      = 4'(mag >> (i - 4));
      end
    end
    if (found) begin
      code = {sign, exp_field, frac};
    end else begin
      code = {sign, 7'b0};
    end
  end

endmodule

// File: rtl/core/eight_bit_alu_with_minifloat_add.sv
// Eight-bit ALU with integer add, OR, AND, XOR and a minifloat add (sign in bit 7,
// excess-3 exponent in bits 6..4, 4-bit fraction with an implicit leading one).
// A three-stage pipeline takes one transaction every cycle while the output is not
// stalled and carries it through its stage registers in order to the output: stage one
// decodes the minifloat operands and computes the integer and bitwise results,
// stage two forms the exact signed sum, and stage three normalizes it into the
// output register. Each stage has its own valid bit and loads when it is empty or
// its successor moves, so a stalled output holds every item in place without loss
// and bubbles are squeezed out.
// Unused mode codes give a zero result.
module eight_bit_alu_with_minifloat_add import ebalu_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  ebalu_in_if.sink  in_if,
  ebalu_out_if.source out_if
);

  logic s1_ready, s2_ready, s3_ready;

  logic                     s1_valid_r;
  logic                     s1_is_float_r;
  data_t                    s1_logic_r;
  logic signed [SVAL_W-1:0] s1_va_r;
  logic signed [SVAL_W-1:0] s1_vb_r;

  logic                     s1_is_float_nxt;
  data_t                    s1_logic_nxt;
  logic [MAG_W-1:0]         mag_a;
  logic [MAG_W-1:0]         mag_b;
  logic signed [SVAL_W-1:0] s1_va_nxt;
  logic signed [SVAL_W-1:0] s1_vb_nxt;

  logic              s2_valid_r;
  logic              s2_is_float_r;
  data_t             s2_logic_r;
  logic              s2_sign_r;
  logic [SMAG_W-1:0] s2_mag_r;

  logic signed [SUM_W-1:0] sum;
  logic                    s2_sign_nxt;
  logic [SMAG_W-1:0]       s2_mag_nxt;

  logic  s3_valid_r;
  data_t s3_result_r;
  data_t float_code;
  data_t s3_result_nxt;

  assign s3_ready    = !s3_valid_r || out_if.ready;
  assign s2_ready    = !s2_valid_r || s3_ready;
  assign s1_ready    = !s1_valid_r || s2_ready;
  assign in_if.ready = s1_ready;

  always_comb begin
    mag_a     = MAG_W'({1'b1, in_if.operand_a[3:0]}) << in_if.operand_a[6:4];
    mag_b     = MAG_W'({1'b1, in_if.operand_b[3:0]}) << in_if.operand_b[6:4];
    s1_va_nxt = in_if.operand_a[7] ? -$signed({1'b0, mag_a}) : $signed({1'b0, mag_a});
    s1_vb_nxt = in_if.operand_b[7] ? -$signed({1'b0, mag_b}) : $signed({1'b0, mag_b});
    s1_is_float_nxt = 1'b0;
    case (in_if.mode)
      MODE_IADD: s1_logic_nxt = in_if.operand_a + in_if.operand_b;
      MODE_FADD: begin
        s1_logic_nxt    = '0;
        s1_is_float_nxt = 1'b1;
      end
      MODE_OR:   s1_logic_nxt = in_if.operand_a | in_if.operand_b;
      MODE_AND:  s1_logic_nxt = in_if.operand_a & in_if.operand_b;
      MODE_XOR:  s1_logic_nxt = in_if.operand_a ^ in_if.operand_b;
      default:   s1_logic_nxt = '0;
    endcase
  end

  always_comb begin
    sum         = SUM_W'(s1_va_r) + SUM_W'(s1_vb_r);
    s2_sign_nxt = sum[SUM_W-1];
    s2_mag_nxt  = s2_sign_nxt ? SMAG_W'(-sum) : SMAG_W'(sum);
  end

  ebalu_norm u_norm (
    .sign (s2_sign_r),
    .mag  (s2_mag_r),
    .code (float_code)
  );

  assign s3_result_nxt = s2_is_float_r ? float_code : s2_logic_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_r <= in_if.valid;
      end
      if (s2_ready) begin
        s2_valid_r <= s1_valid_r;
      end
      if (s3_ready) begin
        s3_valid_r <= s2_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_if.valid) begin
      s1_is_float_r <= s1_is_float_nxt;
      s1_logic_r    <= s1_logic_nxt;
      s1_va_r       <= s1_va_nxt;
      s1_vb_r       <= s1_vb_nxt;
    end
    if (s2_ready && s1_valid_r) begin
      s2_is_float_r <= s1_is_float_r;
      s2_logic_r    <= s1_logic_r;
      s2_sign_r     <= s2_sign_nxt;
      s2_mag_r      <= s2_mag_nxt;
    end
    if (s3_ready && s2_valid_r) begin
      s3_result_r <= s3_result_nxt;
    end
  end

  assign out_if.valid  = s3_valid_r;
  assign out_if.result = s3_result_r;

  a_zero_sum_positive: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r && s2_is_float_r && (s2_mag_r == '0) |-> !s2_sign_r)
    else $error("zero float sum carries a sign");

  a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s2_ready |=> s1_valid_r && $stable(s1_va_r) && $stable(s1_vb_r))
    else $error("stage one lost its item during a stall");

  a_s2_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r && !s3_ready |=> s2_valid_r && $stable(s2_mag_r) && $stable(s2_logic_r))
    else $error("stage two lost its item during a stall");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !s1_valid_r && !s2_valid_r && !s3_valid_r)
    else $error("pipeline not empty after reset");

endmodule
